// File: hw/rtl/wfd_pkg.sv
// ----------------------------------------------------------------------------
// wfd_pkg: shared types and constants for the wall following drive step
// register indexes, bridge modes, stop causes and fixed-point constants
// ----------------------------------------------------------------------------
package wfd_pkg;

  localparam int unsigned COUNT_BITS_DEF = 24;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 23;
  localparam int unsigned TGT_W      = 23;
  localparam int unsigned RANGE_W    = 16;

  localparam logic [RANGE_W-1:0] FRONT_STOP_MM = 16'd60;
  localparam logic [8:0]         RAMP_TICKS    = 9'd300;

  // floor(x / 300) == (x * RECIP_300) >> RECIP_SHIFT for x below 2^18
  localparam int unsigned RECIP_SHIFT = 26;
  localparam logic [17:0] RECIP_300   = 18'd223697;

  localparam logic [7:0]  WALL_SETPOINT_RST  = 8'd45;
  localparam logic [9:0]  WALL_NEAR_RST      = 10'd150;
  localparam logic [7:0]  WALL_GAIN_RST      = 8'd24;
  localparam logic [7:0]  ENCODER_GAIN_RST   = 8'd8;
  localparam logic [7:0]  MAX_CORRECTION_RST = 8'd60;
  localparam logic [7:0]  CRUISE_DUTY_RST    = 8'd120;
  localparam logic [7:0]  MIN_DUTY_RST       = 8'd60;
  localparam logic [22:0] TARGET_TICKS_RST   = 23'd2049;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WALL_SETPOINT  = 3'd0,
    CFG_WALL_NEAR      = 3'd1,
    CFG_WALL_GAIN      = 3'd2,
    CFG_ENCODER_GAIN   = 3'd3,
    CFG_MAX_CORRECTION = 3'd4,
    CFG_CRUISE_DUTY    = 3'd5,
    CFG_MIN_DUTY       = 3'd6,
    CFG_TARGET_TICKS   = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_COAST = 2'd0,
    MODE_FWD   = 2'd1,
    MODE_REV   = 2'd2,
    MODE_BRAKE = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STOP_NONE   = 2'd0,
    STOP_FRONT  = 2'd1,
    STOP_TARGET = 2'd2
  } stop_e;

  typedef struct packed {
    mode_e      mode;
    logic [7:0] duty;
  } drv_t;

endpackage

// File: hw/rtl/wfd_if.sv
// ----------------------------------------------------------------------------
// wfd channel interfaces
// valid/ready channels for the sensor request and the drive result
// ----------------------------------------------------------------------------
interface wfd_in_if import wfd_pkg::*; #(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COUNT_BITS-1:0] left_count;
  logic signed [COUNT_BITS-1:0] right_count;
  logic        [RANGE_W-1:0]    front_range;
  logic        [RANGE_W-1:0]    left_range;
  logic        [RANGE_W-1:0]    right_range;

  modport source (
    output valid, left_count, right_count, front_range, left_range, right_range,
    input  ready
  );
  modport sink (
    input  valid, left_count, right_count, front_range, left_range, right_range,
    output ready
  );
endinterface

interface wfd_out_if;
  logic       valid;
  logic       ready;
  logic       move_done;
  logic [1:0] stop_cause;
  logic [1:0] left_mode;
  logic [7:0] left_duty;
  logic [1:0] right_mode;
  logic [7:0] right_duty;

  modport source (
    output valid, move_done, stop_cause, left_mode, left_duty, right_mode, right_duty,
    input  ready
  );
  modport sink (
    input  valid, move_done, stop_cause, left_mode, left_duty, right_mode, right_duty,
    output ready
  );
endinterface

// File: hw/rtl/wall_following_drive_step_top.sv
// ----------------------------------------------------------------------------
// wall_following_drive_step_top: one control tick of a straight move
// stop check, steering correction, end ramp and bridge drive per tick
// ----------------------------------------------------------------------------
// stages: seven register stages, the result is held in the seventh stage register
// throughput: one request per cycle through seven stages while out_o is not stalled
// stalls: each stage holds while the stage after it is full and stalled
// reset: clears every stage valid bit and loads the register defaults
// ----------------------------------------------------------------------------
module wall_following_drive_step_top import wfd_pkg::*; #(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  wfd_in_if.sink                in_i,
  wfd_out_if.source             out_o
);

  localparam int unsigned NSTG  = 7;
  localparam int unsigned DW    = COUNT_BITS + 1;
  localparam int unsigned CW    = DW + 9;
  localparam int unsigned TRV_W = ((COUNT_BITS > TGT_W) ? COUNT_BITS : TGT_W) + 1;

  // configuration registers
  logic [7:0]       wall_setpoint_q, wall_gain_q, encoder_gain_q;
  logic [7:0]       max_correction_q, cruise_duty_q, min_duty_q;
  logic [9:0]       wall_near_q;
  logic [TGT_W-1:0] target_ticks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wall_setpoint_q  <= WALL_SETPOINT_RST;
      wall_near_q      <= WALL_NEAR_RST;
      wall_gain_q      <= WALL_GAIN_RST;
      encoder_gain_q   <= ENCODER_GAIN_RST;
      max_correction_q <= MAX_CORRECTION_RST;
      cruise_duty_q    <= CRUISE_DUTY_RST;
      min_duty_q       <= MIN_DUTY_RST;
      target_ticks_q   <= TARGET_TICKS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_WALL_SETPOINT:  wall_setpoint_q  <= cfg_data_i[7:0];
        CFG_WALL_NEAR:      wall_near_q      <= cfg_data_i[9:0];
        CFG_WALL_GAIN:      wall_gain_q      <= cfg_data_i[7:0];
        CFG_ENCODER_GAIN:   encoder_gain_q   <= cfg_data_i[7:0];
        CFG_MAX_CORRECTION: max_correction_q <= cfg_data_i[7:0];
        CFG_CRUISE_DUTY:    cruise_duty_q    <= cfg_data_i[7:0];
        CFG_MIN_DUTY:       min_duty_q       <= cfg_data_i[7:0];
        CFG_TARGET_TICKS:   target_ticks_q   <= cfg_data_i[TGT_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline flow control
  logic [NSTG-1:0] v_q;
  logic [NSTG-1:0] en;

  always_comb begin
    en[NSTG-1] = !v_q[NSTG-1] || out_o.ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_i.valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  function automatic drv_t drive_side(logic signed [10:0] s, logic [7:0] mn);
    logic signed [10:0] mns;
    logic signed [10:0] t;
    logic signed [10:0] nt;
    drv_t               d;
    mns = $signed({3'b000, mn});
    t   = s;
    if (t != 11'sd0 && t < mns && t > -mns) begin
      t = t[10] ? -mns : mns;
    end
    if (t > 11'sd255) begin
      t = 11'sd255;
    end
    if (t < -11'sd255) begin
      t = -11'sd255;
    end
    nt = -t;
    if (t > 11'sd0) begin
      d.mode = MODE_FWD;
      d.duty = t[7:0];
    end else if (t < 11'sd0) begin
      d.mode = MODE_REV;
      d.duty = nt[7:0];
    end else begin
      d.mode = MODE_COAST;
      d.duty = 8'd0;
    end
    return d;
  endfunction

  // stage 1: magnitudes, travel, wall flags, correction operand
  logic [COUNT_BITS-1:0] al, ar;
  logic [COUNT_BITS:0]   abs_sum;
  logic                  wl, wr;
  logic signed [DW-1:0]  diff_d;
  logic [7:0]            gain_d;
  logic                  s1_front_q;
  logic [COUNT_BITS-1:0] s1_travel_q;
  logic signed [DW-1:0]  s1_diff_q;
  logic [7:0]            s1_gain_q;

  always_comb begin
    al      = in_i.left_count[COUNT_BITS-1]  ? (~in_i.left_count + 1'b1)
                                             : in_i.left_count;
    ar      = in_i.right_count[COUNT_BITS-1] ? (~in_i.right_count + 1'b1)
                                             : in_i.right_count;
    abs_sum = {1'b0, al} + {1'b0, ar};
    wl      = in_i.left_range  < {6'd0, wall_near_q};
    wr      = in_i.right_range < {6'd0, wall_near_q};
    gain_d  = wall_gain_q;
    if (wl && wr) begin
      diff_d = $signed({{(DW-RANGE_W){1'b0}}, in_i.left_range})
             - $signed({{(DW-RANGE_W){1'b0}}, in_i.right_range});
    end else if (wl) begin
      diff_d = $signed({{(DW-RANGE_W){1'b0}}, in_i.left_range})
             - $signed({{(DW-8){1'b0}}, wall_setpoint_q});
    end else if (wr) begin
      diff_d = $signed({{(DW-8){1'b0}}, wall_setpoint_q})
             - $signed({{(DW-RANGE_W){1'b0}}, in_i.right_range});
    end else begin
      diff_d = $signed({1'b0, ar}) - $signed({1'b0, al});
      gain_d = encoder_gain_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_front_q  <= (in_i.front_range != '0) && (in_i.front_range < FRONT_STOP_MM);
      s1_travel_q <= abs_sum[COUNT_BITS:1];
      s1_diff_q   <= diff_d;
      s1_gain_q   <= gain_d;
    end
  end

  // stage 2: raw correction, target compare, remaining ticks
  logic [TRV_W-1:0]     trv_ext, tgt_ext, rem_full;
  logic                 s2_front_q, s2_tgt_q, s2_near_q;
  logic [8:0]           s2_rem_q;
  logic signed [CW-1:0] s2_corr_q;

  always_comb begin
    trv_ext  = {{(TRV_W-COUNT_BITS){1'b0}}, s1_travel_q};
    tgt_ext  = {{(TRV_W-TGT_W){1'b0}}, target_ticks_q};
    rem_full = tgt_ext - trv_ext;
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s2_front_q <= s1_front_q;
      s2_tgt_q   <= trv_ext >= tgt_ext;
      s2_near_q  <= (trv_ext < tgt_ext) && (rem_full < {{(TRV_W-9){1'b0}}, RAMP_TICKS});
      s2_rem_q   <= rem_full[8:0];
      s2_corr_q  <= CW'(s1_diff_q * $signed({1'b0, s1_gain_q}));
    end
  end

  // stage 3: clamp correction
  logic signed [CW-1:0] lim_s;
  logic signed [12:0]   clamp_d;
  logic                 s3_front_q, s3_tgt_q, s3_near_q;
  logic [8:0]           s3_rem_q;
  logic signed [12:0]   s3_corr_q;

  always_comb begin
    lim_s = $signed({{(CW-12){1'b0}}, max_correction_q, 4'b0000});
    if (s2_corr_q > lim_s) begin
      clamp_d = lim_s[12:0];
    end else if (s2_corr_q < -lim_s) begin
      clamp_d = -lim_s[12:0];
    end else begin
      clamp_d = s2_corr_q[12:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s3_front_q <= s2_front_q;
      s3_tgt_q   <= s2_tgt_q;
      s3_near_q  <= s2_near_q;
      s3_rem_q   <= s2_rem_q;
      s3_corr_q  <= clamp_d;
    end
  end

  // stage 4: wheel speeds, truncating toward zero
  logic signed [13:0] base_s, sum_l, sum_r, adj_l, adj_r;
  logic               s4_front_q, s4_tgt_q, s4_near_q;
  logic [8:0]         s4_rem_q;
  logic signed [9:0]  s4_sl_q, s4_sr_q;

  always_comb begin
    base_s = $signed({2'b00, cruise_duty_q, 4'b0000});
    sum_l  = base_s - {s3_corr_q[12], s3_corr_q};
    sum_r  = base_s + {s3_corr_q[12], s3_corr_q};
    adj_l  = sum_l + $signed({10'd0, {4{sum_l[13]}}});
    adj_r  = sum_r + $signed({10'd0, {4{sum_r[13]}}});
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s4_front_q <= s3_front_q;
      s4_tgt_q   <= s3_tgt_q;
      s4_near_q  <= s3_near_q;
      s4_rem_q   <= s3_rem_q;
      s4_sl_q    <= adj_l[13:4];
      s4_sr_q    <= adj_r[13:4];
    end
  end

  // stage 5: ramp numerator
  logic signed [10:0] dl, dr;
  logic               s5_front_q, s5_tgt_q, s5_near_q;
  logic signed [9:0]  s5_sl_q, s5_sr_q;
  logic signed [20:0] s5_pl_q, s5_pr_q;

  always_comb begin
    dl = {s4_sl_q[9], s4_sl_q} - $signed({3'b000, min_duty_q});
    dr = {s4_sr_q[9], s4_sr_q} - $signed({3'b000, min_duty_q});
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s5_front_q <= s4_front_q;
      s5_tgt_q   <= s4_tgt_q;
      s5_near_q  <= s4_near_q;
      s5_sl_q    <= s4_sl_q;
      s5_sr_q    <= s4_sr_q;
      s5_pl_q    <= $signed({1'b0, s4_rem_q}) * dl;
      s5_pr_q    <= $signed({1'b0, s4_rem_q}) * dr;
    end
  end

  // stage 6: divide magnitude by ramp length through reciprocal
  logic signed [20:0] nl, nr;
  logic [17:0]        ml, mr;
  logic [35:0]        prod_l, prod_r;
  logic               s6_front_q, s6_tgt_q, s6_near_q;
  logic signed [9:0]  s6_sl_q, s6_sr_q;
  logic [8:0]         s6_ql_q, s6_qr_q;
  logic               s6_negl_q, s6_negr_q;

  always_comb begin
    nl     = -s5_pl_q;
    nr     = -s5_pr_q;
    ml     = s5_pl_q[20] ? nl[17:0] : s5_pl_q[17:0];
    mr     = s5_pr_q[20] ? nr[17:0] : s5_pr_q[17:0];
    prod_l = ml * RECIP_300;
    prod_r = mr * RECIP_300;
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      s6_front_q <= s5_front_q;
      s6_tgt_q   <= s5_tgt_q;
      s6_near_q  <= s5_near_q;
      s6_sl_q    <= s5_sl_q;
      s6_sr_q    <= s5_sr_q;
      s6_ql_q    <= prod_l[RECIP_SHIFT+8:RECIP_SHIFT];
      s6_qr_q    <= prod_r[RECIP_SHIFT+8:RECIP_SHIFT];
      s6_negl_q  <= s5_pl_q[20];
      s6_negr_q  <= s5_pr_q[20];
    end
  end

  // stage 7: ramp finish, bridge drive, output register
  logic signed [10:0] ql_s, qr_s, spd_l, spd_r;
  drv_t               drv_l, drv_r;
  logic               s7_done_q;
  stop_e              s7_cause_q;
  drv_t               s7_l_q, s7_r_q;

  always_comb begin
    ql_s  = $signed({2'b00, s6_ql_q});
    qr_s  = $signed({2'b00, s6_qr_q});
    spd_l = {s6_sl_q[9], s6_sl_q};
    spd_r = {s6_sr_q[9], s6_sr_q};
    if (s6_near_q) begin
      spd_l = (s6_negl_q ? -ql_s : ql_s) + $signed({3'b000, min_duty_q});
      spd_r = (s6_negr_q ? -qr_s : qr_s) + $signed({3'b000, min_duty_q});
    end
    drv_l = drive_side(spd_l, min_duty_q);
    drv_r = drive_side(spd_r, min_duty_q);
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      if (s6_front_q || s6_tgt_q) begin
        s7_done_q  <= 1'b1;
        s7_cause_q <= s6_front_q ? STOP_FRONT : STOP_TARGET;
        s7_l_q     <= '{mode: MODE_BRAKE, duty: 8'd0};
        s7_r_q     <= '{mode: MODE_BRAKE, duty: 8'd0};
      end else begin
        s7_done_q  <= 1'b0;
        s7_cause_q <= STOP_NONE;
        s7_l_q     <= drv_l;
        s7_r_q     <= drv_r;
      end
    end
  end

  assign out_o.valid      = v_q[NSTG-1];
  assign out_o.move_done  = s7_done_q;
  assign out_o.stop_cause = 2'(s7_cause_q);
  assign out_o.left_mode  = 2'(s7_l_q.mode);
  assign out_o.left_duty  = s7_l_q.duty;
  assign out_o.right_mode = 2'(s7_r_q.mode);
  assign out_o.right_duty = s7_r_q.duty;

  // checks
  a_backpressure_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (out_o.valid && !out_o.ready))
    else $error("request refused without a stalled result");

  a_done_brakes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.move_done) |->
      (s7_l_q.mode == MODE_BRAKE && s7_r_q.mode == MODE_BRAKE &&
       s7_l_q.duty == 8'd0 && s7_r_q.duty == 8'd0 && s7_cause_q != STOP_NONE))
    else $error("stopped tick without brake");

  a_run_no_brake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.move_done) |->
      (s7_cause_q == STOP_NONE && s7_l_q.mode != MODE_BRAKE &&
       s7_r_q.mode != MODE_BRAKE))
    else $error("running tick with brake or stop cause");

  a_coast_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.move_done) |->
      ((s7_l_q.duty == 8'd0) == (s7_l_q.mode == MODE_COAST) &&
       (s7_r_q.duty == 8'd0) == (s7_r_q.mode == MODE_COAST)))
    else $error("zero duty and coast mode disagree");

  a_min_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.move_done && s7_l_q.duty != 8'd0) |->
      (s7_l_q.duty >= min_duty_q))
    else $error("left duty below minimum");

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for wall_following_drive_step_top
// random and corner sensor requests with random stalls on both channels,
// checked one by one against a drive tick predictor over several settings
// ----------------------------------------------------------------------------
module tb;
  import wfd_pkg::*;

  localparam int unsigned COUNT_BITS   = COUNT_BITS_DEF;
  localparam int          CLK_PERIOD   = 12;
  localparam int          RESET_CYCLES = 8;
  localparam int          DRAIN_CYCLES = 16;
  localparam int          NUM_PHASES   = 9;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          CYCLE_LIMIT  = 400000;
  localparam longint      CNT_MAX      = (longint'(1) <<< (COUNT_BITS - 1)) - 1;
  localparam longint      STOP_MM      = FRONT_STOP_MM;
  localparam longint      RAMP_LEN     = RAMP_TICKS;
  localparam longint      GAIN_ONE     = 16;
  localparam longint      DUTY_MAX     = 255;

  typedef struct packed {
    logic signed [COUNT_BITS-1:0] left_count;
    logic signed [COUNT_BITS-1:0] right_count;
    logic [RANGE_W-1:0]           front_range;
    logic [RANGE_W-1:0]           left_range;
    logic [RANGE_W-1:0]           right_range;
  } tick_req_t;

  typedef struct packed {
    logic  move_done;
    stop_e stop_cause;
    drv_t  left;
    drv_t  right;
  } drive_res_t;

  typedef struct packed {
    logic [7:0]       wall_setpoint;
    logic [9:0]       wall_near;
    logic [7:0]       wall_gain;
    logic [7:0]       encoder_gain;
    logic [7:0]       max_correction;
    logic [7:0]       cruise_duty;
    logic [7:0]       min_duty;
    logic [TGT_W-1:0] target_ticks;
  } drive_regs_t;

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  req_valid  = 1'b0;
  tick_req_t             req_bus    = '0;
  logic                  rsp_ready  = 1'b0;

  wfd_in_if #(.COUNT_BITS(COUNT_BITS)) tick_req_if ();
  wfd_out_if                           drive_rsp_if ();

  assign tick_req_if.valid       = req_valid;
  assign tick_req_if.left_count  = req_bus.left_count;
  assign tick_req_if.right_count = req_bus.right_count;
  assign tick_req_if.front_range = req_bus.front_range;
  assign tick_req_if.left_range  = req_bus.left_range;
  assign tick_req_if.right_range = req_bus.right_range;
  assign drive_rsp_if.ready      = rsp_ready;

  wall_following_drive_step_top #(
    .COUNT_BITS(COUNT_BITS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (tick_req_if),
    .out_o      (drive_rsp_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  drive_regs_t regs = '{
    wall_setpoint:  WALL_SETPOINT_RST,
    wall_near:      WALL_NEAR_RST,
    wall_gain:      WALL_GAIN_RST,
    encoder_gain:   ENCODER_GAIN_RST,
    max_correction: MAX_CORRECTION_RST,
    cruise_duty:    CRUISE_DUTY_RST,
    min_duty:       MIN_DUTY_RST,
    target_ticks:   TARGET_TICKS_RST
  };

  tick_req_t  pending_q[$];
  drive_res_t drive_q[$];
  tick_req_t  held_req;
  drive_res_t got_res;
  drive_res_t want_res;
  int         req_gap;
  logic       req_burst;
  int         rsp_gap;
  logic       rsp_burst;
  int         hold_left;
  int         n_seen;
  int         n_checked;
  int         n_errors;
  int         n_cycles;
  int         n_front;
  int         n_target;
  int         n_rev;
  int         n_coast;
  int         n_full;

  // predictor

  function automatic drv_t to_bridge(longint spd, longint floor_duty);
    drv_t d;
    if (spd != 0 && spd < floor_duty && spd > -floor_duty) begin
      spd = (spd > 0) ? floor_duty : -floor_duty;
    end
    if (spd > DUTY_MAX) spd = DUTY_MAX;
    if (spd < -DUTY_MAX) spd = -DUTY_MAX;
    if (spd > 0) begin
      d.mode = MODE_FWD;
      d.duty = 8'(spd);
    end else if (spd < 0) begin
      d.mode = MODE_REV;
      d.duty = 8'(-spd);
    end else begin
      d.mode = MODE_COAST;
      d.duty = '0;
    end
    return d;
  endfunction

  function automatic drive_res_t drive_tick(tick_req_t rq, drive_regs_t rg);
    drive_res_t rs;
    longint     al, ar, travel, tgt, fr, lr, rr;
    longint     thr, wt, wg, eg, lim, base, mn;
    longint     corr, sl, sr, rem;
    logic       front_hit, wl, wr;
    al     = rq.left_count;
    ar     = rq.right_count;
    al     = (al < 0) ? -al : al;
    ar     = (ar < 0) ? -ar : ar;
    travel = (al + ar) / 2;
    tgt    = rg.target_ticks;
    fr     = rq.front_range;
    lr     = rq.left_range;
    rr     = rq.right_range;
    thr    = rg.wall_near;
    wt     = rg.wall_setpoint;
    wg     = rg.wall_gain;
    eg     = rg.encoder_gain;
    lim    = rg.max_correction;
    base   = rg.cruise_duty;
    mn     = rg.min_duty;
    rs.move_done  = 1'b0;
    rs.stop_cause = STOP_NONE;
    front_hit = (fr > 0) && (fr < STOP_MM);
    if (front_hit || travel >= tgt) begin
      rs.move_done  = 1'b1;
      rs.stop_cause = front_hit ? STOP_FRONT : STOP_TARGET;
      rs.left.mode  = MODE_BRAKE;
      rs.left.duty  = '0;
      rs.right      = rs.left;
      return rs;
    end
    wl = lr < thr;
    wr = rr < thr;
    if (wl && wr) corr = (lr - rr) * wg;
    else if (wl) corr = (lr - wt) * wg;
    else if (wr) corr = -(rr - wt) * wg;
    else corr = -(al - ar) * eg;
    lim = lim * GAIN_ONE;
    if (corr > lim) corr = lim;
    if (corr < -lim) corr = -lim;
    sl = (base * GAIN_ONE - corr) / GAIN_ONE;
    sr = (base * GAIN_ONE + corr) / GAIN_ONE;
    rem = tgt - travel;
    // linear slow down over the last stretch of the move
    if (rem < RAMP_LEN) begin
      sl = (rem * (sl - mn)) / RAMP_LEN + mn;
      sr = (rem * (sr - mn)) / RAMP_LEN + mn;
    end
    rs.left  = to_bridge(sl, mn);
    rs.right = to_bridge(sr, mn);
    return rs;
  endfunction

  // stimulus

  function automatic tick_req_t make_tick(longint lc, longint rc, int unsigned fr,
                                          int unsigned lr, int unsigned rr);
    tick_req_t rq;
    rq.left_count  = COUNT_BITS'(lc);
    rq.right_count = COUNT_BITS'(rc);
    rq.front_range = RANGE_W'(fr);
    rq.left_range  = RANGE_W'(lr);
    rq.right_range = RANGE_W'(rr);
    return rq;
  endfunction

  function automatic logic [RANGE_W-1:0] draw_range(logic [9:0] thr);
    if ($urandom_range(0, 3) == 0) return RANGE_W'($urandom);
    return RANGE_W'($urandom_range(0, 2 * int'(thr) + 20));
  endfunction

  function automatic tick_req_t draw_tick(drive_regs_t rg);
    tick_req_t   rq;
    longint      tgt, t, al, ar, lo, hi, span;
    int unsigned kind;
    logic        even;
    tgt  = rg.target_ticks;
    kind = $urandom_range(0, 19);
    even = ($urandom_range(0, 4) == 0);
    if (kind == 0) begin
      rq.left_count  = COUNT_BITS'($urandom);
      rq.right_count = COUNT_BITS'($urandom);
      rq.front_range = RANGE_W'($urandom);
      rq.left_range  = RANGE_W'($urandom);
      rq.right_range = RANGE_W'($urandom);
      return rq;
    end
    // travel at or past the target, inside the slow-down stretch, or anywhere before it
    if (kind <= 4 && kind >= 3 || tgt == 0) begin
      t = tgt + longint'($urandom_range(0, 600));
      if (t > CNT_MAX) t = CNT_MAX;
    end else if ($urandom_range(0, 2) == 0) begin
      span = (tgt - 1 < RAMP_LEN - 1) ? tgt - 1 : RAMP_LEN - 1;
      t = tgt - 1 - longint'($urandom_range(0, int'(span)));
    end else begin
      t = longint'($urandom_range(0, int'(tgt - 1)));
    end
    lo = (2 * t > CNT_MAX) ? 2 * t - CNT_MAX : 0;
    hi = (2 * t > CNT_MAX) ? CNT_MAX : 2 * t;
    if (even) begin
      al = t;
    end else if ($urandom_range(0, 1) == 0) begin
      al = longint'($urandom_range(int'(lo), int'(hi)));
    end else begin
      al = t - 40 + longint'($urandom_range(0, 80));
      if (al < lo) al = lo;
      if (al > hi) al = hi;
    end
    ar = 2 * t - al;
    if (!even && ar < CNT_MAX && $urandom_range(0, 1) == 1) ar = ar + 1;
    rq.left_count  = COUNT_BITS'(($urandom_range(0, 1) == 1) ? -al : al);
    rq.right_count = COUNT_BITS'(($urandom_range(0, 1) == 1) ? -ar : ar);
    if (kind <= 2) rq.front_range = RANGE_W'($urandom_range(1, int'(STOP_MM) - 1));
    else if ($urandom_range(0, 3) == 0) rq.front_range = '0;
    else rq.front_range = RANGE_W'($urandom_range(int'(STOP_MM), 65535));
    rq.left_range  = draw_range(rg.wall_near);
    rq.right_range = even ? rq.left_range : draw_range(rg.wall_near);
    return rq;
  endfunction

  function automatic string fmt_drive(drive_res_t d);
    return $sformatf("done=%0d cause=%0d left=%0d/%0d right=%0d/%0d", d.move_done,
                     d.stop_cause, d.left.mode, d.left.duty, d.right.mode, d.right.duty);
  endfunction

  task automatic log_error(string msg);
    n_errors++;
    if (n_errors <= 10) $display("tb: mismatch %s", msg);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_WALL_SETPOINT:  regs.wall_setpoint  = data[7:0];
      CFG_WALL_NEAR:      regs.wall_near      = data[9:0];
      CFG_WALL_GAIN:      regs.wall_gain      = data[7:0];
      CFG_ENCODER_GAIN:   regs.encoder_gain   = data[7:0];
      CFG_MAX_CORRECTION: regs.max_correction = data[7:0];
      CFG_CRUISE_DUTY:    regs.cruise_duty    = data[7:0];
      CFG_MIN_DUTY:       regs.min_duty       = data[7:0];
      CFG_TARGET_TICKS:   regs.target_ticks   = data[TGT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_q.size() != 0 || req_valid || drive_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic queue_tick(tick_req_t rq);
    pending_q = {pending_q, rq};
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid <= 1'b0;
      req_bus   <= '0;
      req_gap   = 0;
      req_burst = 1'b0;
    end else begin
      if (req_valid && tick_req_if.ready) begin
        drive_q = {drive_q, drive_tick(held_req, regs)};
      end
      if (!req_valid || tick_req_if.ready) begin
        if (req_gap != 0 || pending_q.size() == 0) begin
          req_valid <= 1'b0;
          if (req_gap != 0) req_gap--;
        end else begin
          held_req = pending_q.pop_front();
          req_bus   <= held_req;
          req_valid <= 1'b1;
          if ($urandom_range(0, 63) == 0) req_burst = !req_burst;
          req_gap = req_burst ? 0 : $urandom_range(0, 15);
        end
      end
    end
  end

  // long receiver hold so the pipeline fills and backs up
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_seen    <= 0;
      hold_left <= 0;
    end else begin
      if (drive_rsp_if.valid && rsp_ready) n_seen <= n_seen + 1;
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end else if (drive_rsp_if.valid && rsp_ready && (n_seen == 519 || n_seen == 1449)) begin
        hold_left <= HOLD_CYCLES;
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_ready <= 1'b0;
      rsp_gap   = 0;
      rsp_burst = 1'b0;
    end else begin
      if (drive_rsp_if.valid && rsp_ready) begin
        got_res.move_done  = drive_rsp_if.move_done;
        got_res.stop_cause = stop_e'(drive_rsp_if.stop_cause);
        got_res.left.mode  = mode_e'(drive_rsp_if.left_mode);
        got_res.left.duty  = drive_rsp_if.left_duty;
        got_res.right.mode = mode_e'(drive_rsp_if.right_mode);
        got_res.right.duty = drive_rsp_if.right_duty;
        if (drive_q.size() == 0) begin
          log_error({"result with nothing pending: ", fmt_drive(got_res)});
        end else begin
          want_res = drive_q.pop_front();
          n_checked++;
          if (got_res.move_done !== want_res.move_done ||
              got_res.stop_cause !== want_res.stop_cause ||
              got_res.left.mode !== want_res.left.mode ||
              got_res.left.duty !== want_res.left.duty ||
              got_res.right.mode !== want_res.right.mode ||
              got_res.right.duty !== want_res.right.duty) begin
            log_error($sformatf("tick %0d: expected %s, got %s", n_checked,
                                fmt_drive(want_res), fmt_drive(got_res)));
          end
          if (want_res.stop_cause == STOP_FRONT) n_front++;
          if (want_res.stop_cause == STOP_TARGET) n_target++;
          n_rev   += (want_res.left.mode == MODE_REV) + (want_res.right.mode == MODE_REV);
          n_coast += (want_res.left.mode == MODE_COAST) + (want_res.right.mode == MODE_COAST);
          n_full  += (want_res.left.duty == 8'hff) + (want_res.right.duty == 8'hff);
        end
        if ($urandom_range(0, 63) == 0) rsp_burst = !rsp_burst;
        rsp_gap = rsp_burst ? 0 : $urandom_range(0, 15);
      end
      if (hold_left != 0) begin
        rsp_ready <= 1'b0;
      end else if (rsp_gap != 0) begin
        rsp_ready <= 1'b0;
        rsp_gap--;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles, %0d results pending", n_cycles, drive_q.size());
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    logic [CFG_DATA_W-1:0] cfg_val;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // settings: reset values, all zero, all ones with excess bits, stand-still corner, random
      if (ph != 0) begin
        for (int k = 0; k < 8; k++) begin
          case (ph)
            1: cfg_val = '0;
            2: cfg_val = '1;
            3: begin
              case (cfg_idx_e'(k))
                CFG_WALL_SETPOINT, CFG_CRUISE_DUTY, CFG_MIN_DUTY: cfg_val = '0;
                default: cfg_val = '1;
              endcase
            end
            default: begin
              if (cfg_idx_e'(k) != CFG_TARGET_TICKS) cfg_val = CFG_DATA_W'($urandom);
              else if ($urandom_range(0, 3) == 0) cfg_val = CFG_DATA_W'($urandom);
              else cfg_val = CFG_DATA_W'($urandom_range(1, 5000));
            end
          endcase
          write_reg(cfg_idx_e'(k), cfg_val);
        end
      end
      @(negedge clk_i);
      if (ph == 0) begin
        queue_tick(make_tick(0, 0, 0, 0, 0));
        queue_tick(make_tick(0, 0, 1, 200, 200));
        queue_tick(make_tick(0, 0, 59, 200, 200));
        queue_tick(make_tick(0, 0, 60, 200, 200));
        queue_tick(make_tick(100, -50, 65535, 65535, 65535));
        queue_tick(make_tick(2049, 2049, 0, 65535, 65535));
        queue_tick(make_tick(2049, 2048, 0, 65535, 65535));
        queue_tick(make_tick(5000, 5000, 30, 65535, 65535));
        queue_tick(make_tick(-CNT_MAX - 1, CNT_MAX, 100, 0, 0));
        queue_tick(make_tick(CNT_MAX, -CNT_MAX - 1, 0, 65535, 65535));
        queue_tick(make_tick(10, 10, 0, 10, 65535));
        queue_tick(make_tick(10, 10, 0, 65535, 149));
        queue_tick(make_tick(10, 10, 0, 150, 150));
        queue_tick(make_tick(1900, -1900, 0, 0, 149));
        queue_tick(make_tick(0, 0, 0, 149, 0));
        queue_tick(make_tick(0, 4000, 0, 65535, 65535));
      end
      for (int n = 0; n < ((ph == 1) ? 150 : 250); n++) queue_tick(draw_tick(regs));
      wait_drained();
    end
    $display("tb: %0d drive ticks checked over %0d register settings, %0d errors",
             n_checked, NUM_PHASES, n_errors);
    $display("tb: %0d front stops, %0d target stops, wheels: %0d reverse %0d coast %0d full duty",
             n_front, n_target, n_rev, n_coast, n_full);
    if (n_errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
